/* rtl/bpa_pkg.sv */
// Shared types, codes and constants of the bitmap page allocator.
// No dependencies; every other file of the block but bpa_ifs.sv imports this package.
`timescale 1ns / 1ps

package bpa_pkg;

   // Defaults of the top-level parameters.
   localparam int POOL_PAGES_DEF = 4096;
   localparam int MAX_RUN_DEF    = 64;

   // Defaults of the derived widths handed down to the submodules.
   localparam int MAP_WORDS_DEF = 64;
   localparam int WA_W_DEF      = 6;
   localparam int GX_W_DEF      = 13;

   // Bitmap words are 64 bits wide; a bit position inside a word takes 6 bits.
   localparam int WORD_BITS  = 64;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = 12;

   // Register file.
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_VIRT_BASE  = 2'd0;
   localparam logic [1:0] REG_PHYS_BASE  = 2'd1;
   localparam logic [1:0] REG_VIRT_PAGES = 2'd2;
   localparam logic [1:0] REG_PHYS_PAGES = 2'd3;

   localparam logic [31:0] VIRT_BASE_RST  = 32'hC010_0000;
   localparam logic [31:0] PHYS_BASE_RST  = 32'h0020_0000;
   localparam logic [12:0] VIRT_PAGES_RST = 13'd3840;
   localparam logic [12:0] PHYS_PAGES_RST = 13'd3840;

   typedef struct packed {
      logic [31:0] virt_base;
      logic [31:0] phys_base;
      logic [12:0] virt_pages;
      logic [12:0] phys_pages;
   } cfg_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_VIRT = 2'd1,
      STATUS_NO_PHYS = 2'd2,
      STATUS_BAD_REQ = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ERR,
      S_VFETCH,
      S_VSCAN,
      S_VMRD,
      S_VMWR,
      S_PSTART,
      S_PFETCH,
      S_PSCAN
   } bpa_state_type;

   // Control of the shared find-first unit and its answer.
   typedef struct packed {
      logic       seek_free;
      logic [5:0] from_pos;
   } find_ctl_type;

   typedef struct packed {
      logic       found;
      logic [5:0] pos;
   } find_res_type;

endpackage

/* rtl/bpa_ifs.sv */
// Valid/ready channel interfaces for the request and the result beats.
// Depends on nothing; used by the top level of the allocator.
`timescale 1ns / 1ps

interface bpa_req_if;
   logic       valid;
   logic       ready;
   logic       pool_select;
   logic [6:0] page_count;

   modport source (output valid, output pool_select, output page_count, input ready);
   modport sink   (input valid, input pool_select, input page_count, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] virt_addr;
   logic [31:0] phys_addr;
   logic        last;

   modport source (output valid, output status, output virt_addr, output phys_addr,
                   output last, input ready);
   modport sink   (input valid, input status, input virt_addr, input phys_addr,
                   input last, output ready);
endinterface

/* rtl/bitmap_page_allocator.sv */
// Bitmap page allocator, top level: first-fit virtual run search, then one physical page per beat.
// One request is handled at a time: the virtual search reads the bitmap words in turn, the run is
// marked in one or two words, then each page is taken from the lowest physical word not yet full.
// Reset: synchronous; a clearing pass zeroes both bitmaps word by word before the first request
// beat is taken. Register writes are taken during the pass.
`timescale 1ns / 1ps

module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int POOL_PAGES = POOL_PAGES_DEF,
   parameter int MAX_RUN    = MAX_RUN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bpa_req_if.sink           req_bus,
   bpa_rsp_if.source         rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // Both bitmaps are stored as 64-bit words. A global bit index is {word, position}; GX_W
   // carries one spare bit so that the page limits and "end of word" bases compare cleanly.
   localparam int MAP_WORDS = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int GX_W      = WA_W + 7;

   cfg_type cfg;

   bpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Registers of the sequencer.
   // ------------------------------------------------------------------
   bpa_state_type   state_ff, state_in;
   logic [WA_W-1:0] clr_ff, clr_in;           // clearing pass word address
   logic [6:0]      cnt_ff, cnt_in;           // pages asked for
   status_type      err_ff, err_in;           // code of the pending error beat
   logic [WA_W-1:0] v_wi_ff, v_wi_in;         // virtual word under scan
   logic [5:0]      pos_ff, pos_in;           // scan cursor inside that word
   logic            run_ff, run_in;           // 1 while inside a free run
   logic [6:0]      run_len_ff, run_len_in;   // free bits of the run before the cursor word
   logic [GX_W-1:0] run_start_ff, run_start_in;
   logic            hi_ff, hi_in;             // marking the second word of the run
   logic [31:0]     va_ff, va_in;             // virtual address of the next page
   logic [6:0]      page_ff, page_in;         // pages handed out so far
   logic [WA_W-1:0] p_hint_ff, p_hint_in;     // every physical word below this one is full

   // Result register; a result beat waits here while the sequencer goes on.
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic [31:0]     rsp_va_ff, rsp_va_in;
   logic [31:0]     rsp_pa_ff, rsp_pa_in;
   logic            rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------------
   // Bitmap memories and the shared find-first unit.
   // ------------------------------------------------------------------
   logic                 v_wr_en, v_rd_en, p_wr_en, p_rd_en;
   logic [WA_W-1:0]      v_wr_addr, v_rd_addr, p_wr_addr, p_rd_addr;
   logic [WORD_BITS-1:0] v_wr_data, p_wr_data, v_rd_data, p_rd_data;

   bpa_map_ram #(.WORDS(MAP_WORDS), .AW(WA_W)) u_virt_map (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_en   (v_rd_en),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   bpa_map_ram #(.WORDS(MAP_WORDS), .AW(WA_W)) u_phys_map (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_en   (p_rd_en),
      .rd_addr (p_rd_addr),
      .rd_data (p_rd_data)
   );

   // The page limits are clamped to the size of the bitmaps.
   logic [GX_W-1:0] vlim, plim;
   assign vlim = (32'(cfg.virt_pages) > 32'(POOL_PAGES)) ? GX_W'(POOL_PAGES)
                                                         : GX_W'(cfg.virt_pages);
   assign plim = (32'(cfg.phys_pages) > 32'(POOL_PAGES)) ? GX_W'(POOL_PAGES)
                                                         : GX_W'(cfg.phys_pages);

   // One find-first unit serves both phases. In the physical phase it always looks for the
   // lowest free bit of the hint word; in the virtual phase it looks for the next free bit
   // (outside a run) or the next used bit (inside a run) from the cursor on.
   logic                 phys_phase;
   logic [WORD_BITS-1:0] fu_word;
   logic [WA_W-1:0]      fu_widx;
   logic [GX_W-1:0]      fu_lim;
   find_ctl_type         fu_ctl;
   find_res_type         fu_res;

   assign phys_phase       = (state_ff == S_PSCAN);
   assign fu_word          = phys_phase ? p_rd_data : v_rd_data;
   assign fu_widx          = phys_phase ? p_hint_ff : v_wi_ff;
   assign fu_lim           = phys_phase ? plim : vlim;
   assign fu_ctl.seek_free = phys_phase ? 1'b1 : !run_ff;
   assign fu_ctl.from_pos  = phys_phase ? 6'd0 : pos_ff;

   bpa_find_unit #(.WA_W(WA_W), .GX_W(GX_W)) u_find (
      .word     (fu_word),
      .word_idx (fu_widx),
      .lim      (fu_lim),
      .ctl      (fu_ctl),
      .res      (fu_res)
   );

   // ------------------------------------------------------------------
   // Helper terms.
   // ------------------------------------------------------------------
   logic            req_bad;
   logic            out_free;
   logic [6:0]      seg;
   logic [7:0]      total;
   logic            run_done;
   logic            v_adv;
   logic [GX_W-1:0] v_next_base, p_next_base;
   logic            v_last_word, p_last_word;
   logic            page_last;
   logic [WA_W-1:0] mark_addr;
   logic [63:0]     run_ones;
   logic [127:0]    run_mask;
   logic [63:0]     mask_sel;

   assign req_bad = !req_bus.pool_select || (req_bus.page_count == 7'd0) ||
                    (req_bus.page_count > 7'(MAX_RUN));

   // The result register can take a new beat when it is empty or is being emptied now.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Inside a run, the free stretch of this word ends at the next used bit, or at the end
   // of the word when there is none. The run is long enough once the count is reached.
   assign seg      = (fu_res.found ? {1'b0, fu_res.pos} : 7'd64) - {1'b0, pos_ff};
   assign total    = {1'b0, run_len_ff} + {1'b0, seg};
   assign run_done = run_ff && (total >= {1'b0, cnt_ff});
   assign v_adv    = !fu_res.found && !run_done;

   // The scan stops when the next word would start at or beyond the limit.
   assign v_next_base = {({1'b0, v_wi_ff} + (WA_W + 1)'(1)), 6'd0};
   assign p_next_base = {({1'b0, p_hint_ff} + (WA_W + 1)'(1)), 6'd0};
   assign v_last_word = (v_next_base >= vlim);
   assign p_last_word = (p_next_base >= plim);

   assign page_last = ((page_ff + 7'd1) == cnt_ff);

   // A run of up to 64 bits touches at most two words; the mask is built once over both.
   assign mark_addr = run_start_ff[GX_W-2:6] + WA_W'(hi_ff);
   assign run_ones  = (cnt_ff >= 7'd64) ? '1 : ((64'd1 << cnt_ff[5:0]) - 64'd1);
   assign run_mask  = {64'd0, run_ones} << run_start_ff[5:0];
   assign mask_sel  = hi_ff ? run_mask[127:64] : run_mask[63:0];

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == WA_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               state_in = req_bad ? S_ERR : S_VFETCH;
            end
         end
         S_ERR: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_VFETCH: state_in = S_VSCAN;
         S_VSCAN: begin
            if (run_done) begin
               state_in = S_VMRD;
            end else if (v_adv) begin
               state_in = v_last_word ? S_ERR : S_VFETCH;
            end
         end
         S_VMRD: state_in = S_VMWR;
         S_VMWR: begin
            if (!hi_ff && (run_mask[127:64] != 64'd0)) begin
               state_in = S_VMRD;
            end else begin
               state_in = S_PSTART;
            end
         end
         S_PSTART: state_in = S_PFETCH;
         S_PFETCH: state_in = S_PSCAN;
         S_PSCAN: begin
            if (fu_res.found) begin
               if (out_free) begin
                  state_in = page_last ? S_IDLE : S_PFETCH;
               end
            end else begin
               state_in = p_last_word ? S_ERR : S_PFETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs and datapath of each state.
   // ------------------------------------------------------------------
   always_comb begin
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      v_wi_in       = v_wi_ff;
      pos_in        = pos_ff;
      run_in        = run_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      hi_in         = hi_ff;
      va_in         = va_ff;
      page_in       = page_ff;
      p_hint_in     = p_hint_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_va_in     = rsp_va_ff;
      rsp_pa_in     = rsp_pa_ff;
      rsp_last_in   = rsp_last_ff;

      req_bus.ready = 1'b0;
      v_wr_en       = 1'b0;
      v_wr_addr     = mark_addr;
      v_wr_data     = v_rd_data | mask_sel;
      v_rd_en       = 1'b0;
      v_rd_addr     = v_wi_ff;
      p_wr_en       = 1'b0;
      p_wr_addr     = p_hint_ff;
      p_wr_data     = p_rd_data | (64'd1 << fu_res.pos);
      p_rd_en       = 1'b0;
      p_rd_addr     = p_hint_ff;

      case (state_ff)
         S_CLEAR: begin
            v_wr_en   = 1'b1;
            v_wr_addr = clr_ff;
            v_wr_data = '0;
            p_wr_en   = 1'b1;
            p_wr_addr = clr_ff;
            p_wr_data = '0;
            clr_in    = clr_ff + WA_W'(1);
         end
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               cnt_in     = req_bus.page_count;
               err_in     = STATUS_BAD_REQ;
               v_wi_in    = '0;
               pos_in     = 6'd0;
               run_in     = 1'b0;
               run_len_in = 7'd0;
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_ff;
               rsp_va_in     = 32'd0;
               rsp_pa_in     = 32'd0;
               rsp_last_in   = 1'b1;
            end
         end
         S_VFETCH: begin
            v_rd_en = 1'b1;
         end
         S_VSCAN: begin
            if (run_done) begin
               hi_in = 1'b0;
            end else if (v_adv) begin
               // Nothing more in this word: carry the run length into the next one.
               run_len_in = run_ff ? total[6:0] : 7'd0;
               v_wi_in    = v_wi_ff + WA_W'(1);
               pos_in     = 6'd0;
               if (v_last_word) begin
                  err_in = STATUS_NO_VIRT;
               end
            end else if (run_ff) begin
               // A used bit breaks the run short of the count.
               run_in     = 1'b0;
               run_len_in = 7'd0;
               pos_in     = fu_res.pos;
            end else begin
               // A free bit opens a new run.
               run_in       = 1'b1;
               run_len_in   = 7'd0;
               pos_in       = fu_res.pos;
               run_start_in = GX_W'({v_wi_ff, fu_res.pos});
            end
         end
         S_VMRD: begin
            v_rd_en   = 1'b1;
            v_rd_addr = mark_addr;
         end
         S_VMWR: begin
            v_wr_en = 1'b1;
            if (!hi_ff && (run_mask[127:64] != 64'd0)) begin
               hi_in = 1'b1;
            end
         end
         S_PSTART: begin
            va_in   = cfg.virt_base + (32'(run_start_ff) << PAGE_SHIFT);
            page_in = 7'd0;
         end
         S_PFETCH: begin
            p_rd_en = 1'b1;
         end
         S_PSCAN: begin
            if (fu_res.found) begin
               if (out_free) begin
                  p_wr_en       = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_va_in     = va_ff;
                  rsp_pa_in     = cfg.phys_base + (32'({p_hint_ff, fu_res.pos}) << PAGE_SHIFT);
                  rsp_last_in   = page_last;
                  va_in         = va_ff + 32'(PAGE_BYTES);
                  page_in       = page_ff + 7'd1;
               end
            end else if (p_last_word) begin
               err_in = STATUS_NO_PHYS;
            end else begin
               // The whole word lies below the limit and is full; it never frees again.
               p_hint_in = p_hint_ff + WA_W'(1);
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         p_hint_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         p_hint_ff    <= p_hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      err_ff        <= err_in;
      v_wi_ff       <= v_wi_in;
      pos_ff        <= pos_in;
      run_ff        <= run_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      hi_ff         <= hi_in;
      va_ff         <= va_in;
      page_ff       <= page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_va_ff     <= rsp_va_in;
      rsp_pa_ff     <= rsp_pa_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.virt_addr = rsp_va_ff;
   assign rsp_bus.phys_addr = rsp_pa_ff;
   assign rsp_bus.last      = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
`ifndef SYNTH
   // While a beat that is not the last of its request waits, the request is still in work.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != S_IDLE))
      else $error("non-final result pending while the sequencer is idle");

   // Physical pages are never freed, so the full-word hint only moves up.
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> (p_hint_ff >= $past(p_hint_ff)))
      else $error("physical hint moved backward");

   // A run that reached the requested count must have left the scan state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VSCAN) |-> (run_len_ff < cnt_ff))
      else $error("carried run length reached the request count");
`endif

endmodule

/* rtl/bpa_csr.sv */
// APB-style register file holding the base addresses and page limits.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_csr
   import bpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_VIRT_BASE:  cfg_in.virt_base  = csr_pwdata;
            REG_PHYS_BASE:  cfg_in.phys_base  = csr_pwdata;
            REG_VIRT_PAGES: cfg_in.virt_pages = csr_pwdata[12:0];
            REG_PHYS_PAGES: cfg_in.phys_pages = csr_pwdata[12:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_VIRT_BASE:  csr_prdata = cfg_ff.virt_base;
         REG_PHYS_BASE:  csr_prdata = cfg_ff.phys_base;
         REG_VIRT_PAGES: csr_prdata = {19'd0, cfg_ff.virt_pages};
         REG_PHYS_PAGES: csr_prdata = {19'd0, cfg_ff.phys_pages};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.virt_base  <= VIRT_BASE_RST;
         cfg_ff.phys_base  <= PHYS_BASE_RST;
         cfg_ff.virt_pages <= VIRT_PAGES_RST;
         cfg_ff.phys_pages <= PHYS_PAGES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/bpa_map_ram.sv */
// Single-port-write, single-port-read word memory holding one page bitmap.
// Depends on bpa_pkg for the word width.
`timescale 1ns / 1ps

module bpa_map_ram
   import bpa_pkg::*;
#(
   parameter int WORDS = MAP_WORDS_DEF,
   parameter int AW    = WA_W_DEF
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bpa_find_unit.sv */
// Find-first unit: lowest free (or used) bit of a bitmap word at or above a
// start position, with bits at or beyond the page limit counted as used.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_find_unit
   import bpa_pkg::*;
#(
   parameter int WA_W = WA_W_DEF,
   parameter int GX_W = GX_W_DEF
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic [WA_W-1:0]      word_idx,
   input  logic [GX_W-1:0]      lim,
   input  find_ctl_type         ctl,
   output find_res_type         res
);

   logic [GX_W-1:0]      base;
   logic [GX_W-1:0]      diff;
   logic [6:0]           avail;
   logic [WORD_BITS-1:0] in_lim;
   logic [WORD_BITS-1:0] from_ok;
   logic [WORD_BITS-1:0] cand;

   assign base = GX_W'({word_idx, 6'd0});
   assign diff = lim - base;

   // Number of bits of this word that lie below the limit, 0 to 64.
   always_comb begin
      if (lim <= base) begin
         avail = 7'd0;
      end else if (diff >= GX_W'(WORD_BITS)) begin
         avail = 7'd64;
      end else begin
         avail = diff[6:0];
      end
   end

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         in_lim[j]  = (7'(j) < avail);
         from_ok[j] = (6'(j) >= ctl.from_pos);
      end
   end

   assign cand = ctl.seek_free ? (~word & in_lim & from_ok) : ((word | ~in_lim) & from_ok);

   always_comb begin
      res.found = |cand;
      res.pos   = 6'd0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (cand[j]) begin
            res.pos = 6'(j);
         end
      end
   end

endmodule

/* tb/tb.sv */
// Self-checking testbench of the bitmap page allocator: directed and random page requests,
// APB register set-up between phases, and an in-order beat predictor held in a small class.
// Depends on bpa_pkg and the channel interfaces in bpa_ifs.sv, and on the RTL top level.
`timescale 1ns / 1ps

module tb;
   import bpa_pkg::*;

   // Pool selector codes of a request.
   localparam bit POOL_USER   = 1'b0;
   localparam bit POOL_KERNEL = 1'b1;

   // The run is ended by force after this many clock cycles.
   localparam int unsigned CYCLE_LIMIT = 5_000_000;

   // Predictor of the allocator. It keeps its own copy of both used-page bitmaps and of the
   // registers, turns each accepted request into the beats the block must answer with, and
   // checks every result beat against the oldest of them.
   class page_map_scoreboard;
      typedef struct {
         status_type  status;
         logic [31:0] virt_addr;
         logic [31:0] phys_addr;
         logic        last;
      } page_beat_type;

      bit [POOL_PAGES_DEF-1:0] virt_taken;
      bit [POOL_PAGES_DEF-1:0] phys_taken;
      logic [31:0]             virt_base;
      logic [31:0]             phys_base;
      logic [12:0]             virt_pages;
      logic [12:0]             phys_pages;
      page_beat_type           due_pages[$];
      int unsigned             errors;

      function new();
         virt_taken = '0;
         phys_taken = '0;
         virt_base  = VIRT_BASE_RST;
         phys_base  = PHYS_BASE_RST;
         virt_pages = VIRT_PAGES_RST;
         phys_pages = PHYS_PAGES_RST;
         errors     = 0;
      endfunction

      function void write_reg(logic [1:0] which, logic [31:0] value);
         case (which)
            REG_VIRT_BASE:  virt_base  = value;
            REG_PHYS_BASE:  phys_base  = value;
            REG_VIRT_PAGES: virt_pages = value[12:0];
            REG_PHYS_PAGES: phys_pages = value[12:0];
            default: ;
         endcase
      endfunction

      // Lowest start of n free bits among the first limit_pages bits, or -1.
      function int lowest_free_run(bit [POOL_PAGES_DEF-1:0] map, logic [12:0] limit_pages,
                                   int n);
         int lim;
         int run;
         lim = (limit_pages > POOL_PAGES_DEF) ? POOL_PAGES_DEF : int'(limit_pages);
         run = 0;
         for (int i = 0; i < lim; i++) begin
            if (map[i]) begin
               run = 0;
            end else begin
               run++;
               if (run == n) return i + 1 - n;
            end
         end
         return -1;
      endfunction

      function void queue_page(status_type st, logic [31:0] va, logic [31:0] pa, logic last);
         page_beat_type beat;
         beat.status    = st;
         beat.virt_addr = va;
         beat.phys_addr = pa;
         beat.last      = last;
         due_pages.push_back(beat);
      endfunction

      function void take_request(bit pool, bit [6:0] count);
         int start;
         int frame;
         if (pool == POOL_USER || count == 0 || count > MAX_RUN_DEF) begin
            queue_page(STATUS_BAD_REQ, '0, '0, 1'b1);
            return;
         end
         start = lowest_free_run(virt_taken, virt_pages, count);
         if (start < 0) begin
            queue_page(STATUS_NO_VIRT, '0, '0, 1'b1);
            return;
         end
         for (int i = 0; i < count; i++) virt_taken[start + i] = 1'b1;
         for (int i = 0; i < count; i++) begin
            frame = lowest_free_run(phys_taken, phys_pages, 1);
            if (frame < 0) begin
               // The virtual run and the frames taken so far stay marked.
               queue_page(STATUS_NO_PHYS, '0, '0, 1'b1);
               return;
            end
            phys_taken[frame] = 1'b1;
            queue_page(STATUS_OK,
                       virt_base + 32'(start + i) * 32'(PAGE_BYTES),
                       phys_base + 32'(frame) * 32'(PAGE_BYTES),
                       (i + 1 == count));
         end
      endfunction

      // Every mismatch is printed on one line and counted.
      task report(string what);
         errors++;
         $display("ERROR at %0t ns: %s", $time, what);
      endtask

      task check_page(logic [1:0] status, logic [31:0] va, logic [31:0] pa, logic last);
         page_beat_type want;
         if (due_pages.size() == 0) begin
            report($sformatf("unexpected beat: status %0d virt %h phys %h last %b",
                             status, va, pa, last));
            return;
         end
         want = due_pages.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, expected %s", status, want.status.name()));
         if (va !== want.virt_addr)
            report($sformatf("virt_addr %h, expected %h", va, want.virt_addr));
         if (pa !== want.phys_addr)
            report($sformatf("phys_addr %h, expected %h", pa, want.phys_addr));
         if (last !== want.last)
            report($sformatf("last %b, expected %b", last, want.last));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   bpa_req_if req_bus();
   bpa_rsp_if rsp_bus();

   page_map_scoreboard page_maps = new();

   // Chance in percent that the sender skips a cycle, and that the receiver refuses a beat.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count   = 0;

   bitmap_page_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Every result beat is checked at the edge that accepts it. Values read here are the ones
   // from before the edge, so the order of processes within the step does not matter.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         page_maps.check_page(rsp_bus.status, rsp_bus.virt_addr, rsp_bus.phys_addr,
                              rsp_bus.last);
      end
   end

   // Receiver. Ready is drawn afresh every cycle from the current idle chance. Once, after a
   // couple of hundred beats, it holds off for a long stretch while the sender keeps offering
   // requests, so the block backs up and stops taking new ones.
   initial begin
      int unsigned beats_taken;
      int unsigned hold_left;
      bit          held_once;
      beats_taken = 0;
      hold_left   = 0;
      held_once   = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) beats_taken++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held_once && beats_taken >= 200) begin
            held_once = 1'b1;
            hold_left = 600;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // APB write: a setup phase, then an access phase that completes while pready is high. A
   // closing idle wait keeps back-to-back writes from driving psel twice in a step.
   task automatic csr_write(input logic [1:0] which, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      page_maps.write_reg(which, value);
      @(posedge clock);
   endtask

   task automatic set_pool(input logic [31:0] vbase, input logic [31:0] pbase,
                           input logic [31:0] vpages, input logic [31:0] ppages);
      csr_write(REG_VIRT_BASE, vbase);
      csr_write(REG_PHYS_BASE, pbase);
      csr_write(REG_VIRT_PAGES, vpages);
      csr_write(REG_PHYS_PAGES, ppages);
   endtask

   // Offer one request beat. Valid is left high after the beat is taken: the next call either
   // keeps it high with new payload or lowers it while idling, so it is driven once a step.
   task automatic send_request(input bit pool, input bit [6:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pool_select <= pool;
      req_bus.page_count  <= count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      page_maps.take_request(pool, count);
   endtask

   // Most random requests are well formed and mostly small, so the bitmaps last the whole run
   // while a few long runs still come through. The rest are user-pool and bad-count requests.
   task automatic send_random_request();
      int unsigned pick;
      int unsigned span;
      bit          pool;
      bit [6:0]    count;
      pick = $urandom_range(99);
      span = $urandom_range(99);
      if (pick < 85) begin
         pool = POOL_KERNEL;
         if (span < 70)      count = 7'($urandom_range(4, 1));
         else if (span < 90) count = 7'($urandom_range(16, 5));
         else                count = 7'($urandom_range(MAX_RUN_DEF, 17));
      end else if (pick < 92) begin
         pool  = POOL_USER;
         count = 7'($urandom_range(127));
      end else begin
         pool  = POOL_KERNEL;
         count = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, MAX_RUN_DEF + 1));
      end
      send_request(pool, count);
   endtask

   // Stop offering and wait until every predicted beat has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (page_maps.due_pages.size() != 0);
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.pool_select = POOL_KERNEL;
      req_bus.page_count  = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // First stretch: the sender rarely idles, the receiver mostly refuses.
      send_idle_pct = 14;
      recv_idle_pct = 66;

      // Directed requests at the reset settings: the smallest and the largest run, zero and
      // oversized counts, and the user pool, which is always refused.
      send_request(POOL_KERNEL, 7'd1);
      send_request(POOL_KERNEL, 7'(MAX_RUN_DEF));
      send_request(POOL_KERNEL, 7'd0);
      send_request(POOL_KERNEL, 7'(MAX_RUN_DEF + 1));
      send_request(POOL_KERNEL, 7'd127);
      send_request(POOL_USER, 7'd1);
      send_request(POOL_USER, 7'd0);
      send_request(POOL_USER, 7'd127);
      send_request(POOL_KERNEL, 7'd2);
      wait_idle();

      // Physical pages run out partway: three frames left for a ten-page run, then none left
      // at all, so the error comes before any page.
      csr_write(REG_PHYS_PAGES, 32'($countones(page_maps.phys_taken) + 3));
      send_request(POOL_KERNEL, 7'd10);
      send_request(POOL_KERNEL, 7'd1);
      wait_idle();
      csr_write(REG_PHYS_PAGES, 32'd0);
      send_request(POOL_KERNEL, 7'd1);
      wait_idle();

      // Virtual window one page short of the request, then an exact fit, then full; last an
      // empty window.
      csr_write(REG_PHYS_PAGES, 32'(POOL_PAGES_DEF));
      csr_write(REG_VIRT_PAGES, 32'($countones(page_maps.virt_taken) + 2));
      send_request(POOL_KERNEL, 7'd3);
      send_request(POOL_KERNEL, 7'd2);
      send_request(POOL_KERNEL, 7'd1);
      wait_idle();
      csr_write(REG_VIRT_PAGES, 32'd0);
      send_request(POOL_KERNEL, 7'd1);
      send_request(POOL_USER, 7'd1);
      wait_idle();

      // Random, phase one: bases near the top of the address space so addresses wrap, and
      // page limits beyond the bitmap so they are clamped.
      set_pool(32'hFFFF_F000, 32'hFFFF_E123, 32'd8191, 32'd5000);
      for (int n = 0; n < 70; n++) send_random_request();
      wait_idle();

      // Phase two: the roles swap, and both windows are nearly full so the out-of-pages
      // errors turn up often.
      send_idle_pct = 66;
      recv_idle_pct = 14;
      set_pool($urandom, $urandom, 32'($countones(page_maps.virt_taken) + 60),
               32'($countones(page_maps.phys_taken) + 30));
      for (int n = 0; n < 40; n++) send_random_request();
      wait_idle();

      // Phase three: zero bases, the whole bitmap, no idling on either side. Halfway through
      // the sender pauses until everything is back.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_pool(32'd0, 32'd0, 32'(POOL_PAGES_DEF), 32'(POOL_PAGES_DEF));
      for (int n = 0; n < 95; n++) begin
         if (n == 45) wait_idle();
         send_random_request();
      end
      wait_idle();

      // Let a late stray beat show up before the verdict.
      repeat (200) @(posedge clock);
      if (page_maps.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
